// ===== design/gwsm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the grouped weighted sum block.
// No dependencies; imported by gwsm_store, grouped_weighted_sum_with_missing and tb_top.
`timescale 1ns / 1ps

package gwsm_pkg;

    // Field widths
    localparam int GROUP_W    = 6;
    localparam int VALUE_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int ACC_W      = 64;
    localparam int GCOUNT_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 72;

    // Highest group count the index field can address
    localparam int MAX_GROUPS = 1 << GROUP_W;

    // Action codes carried on s_tuser
    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_MISSING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_WEIGHTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT  = 2'd2;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // One group's stored state
    typedef struct packed {
        logic             poisoned;
        logic             seen;
        logic [ACC_W-1:0] acc;
    } entry_t;

    // Write port of the group store
    typedef struct packed {
        logic               en;
        logic [GROUP_W-1:0] group;
        entry_t             entry;
    } store_wr_t;

    // Signed add that clamps to the 64-bit range
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W-1:0] s;
        s = a + b;
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
            return a[ACC_W-1] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

endpackage

// ===== design/grouped_weighted_sum_with_missing.sv =====
// Grouped weighted sum with missing-value handling; top level with config port and streams.
// Pipeline: stage 1 register and multiply, stage 2 register and update, then the output
// register that drives m_tvalid. Throughput: one item per cycle; the pipeline halts only while
// the output register holds a result that m_tready has not taken. Group state lives in a
// memory of up to 64 entries whose entries carry valid flags, so reset clears all groups at
// once without a sweep; configuration resets to skip_missing 1, use_weights 0, group_count 0.
`timescale 1ns / 1ps

module grouped_weighted_sum_with_missing
    import gwsm_pkg::*;
#(
    parameter int NUM_GROUPS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: group_index[5:0], sample_value[37:6], sample_missing[38],
    //          sample_weight[70:39], weight_missing[71]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: action[0]
    input  logic                  s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: group_sum[63:0], sum_is_missing[64], read_group[70:65], zero[71]
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int DEPTH = (NUM_GROUPS < MAX_GROUPS) ? NUM_GROUPS : MAX_GROUPS;

    // Configuration registers
    logic                skip_missing_reg;
    logic                use_weights_reg;
    logic [GCOUNT_W-1:0] group_count_reg;

    // Stage 1
    logic                      p1_valid_reg;
    logic                      p1_action_reg;
    logic [GROUP_W-1:0]        p1_group_reg;
    logic                      p1_ok_reg;
    logic signed [VALUE_W-1:0] p1_value_reg;
    logic                      p1_vmiss_reg;
    logic signed [VALUE_W-1:0] p1_weight_reg;
    logic                      p1_wmiss_reg;

    // Stage 2
    logic               p2_valid_reg;
    logic               p2_action_reg;
    logic [GROUP_W-1:0] p2_group_reg;
    logic               p2_ok_reg;
    logic               p2_miss_reg;
    logic [ACC_W-1:0]   p2_term_reg;
    entry_t             p2_entry_reg;

    // Last store write, for the read that was taken on the same edge
    logic               wb_en_reg;
    logic [GROUP_W-1:0] wb_group_reg;
    entry_t             wb_entry_reg;

    // Output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic                  advance;
    logic [GROUP_W-1:0]    in_index;
    logic [GROUP_W-1:0]    in_group;
    logic                  in_ok;
    entry_t                rd_entry;
    entry_t                p1_entry;
    logic signed [ACC_W-1:0] p1_prod;
    logic [ACC_W-1:0]      p1_term;
    logic                  p1_miss;
    entry_t                p2_entry_next;
    logic [ACC_W-1:0]      res_sum;
    logic                  res_miss;
    logic                  rd_miss;
    store_wr_t             st_wr;
    logic [M_TDATA_W-1:0]  m_data_next;

    // Whole pipeline moves when the output register can take a result
    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_missing_reg <= 1'b1;
            use_weights_reg  <= 1'b0;
            group_count_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SKIP_MISSING: skip_missing_reg <= cfg_data[0];
                CFG_USE_WEIGHTS:  use_weights_reg  <= cfg_data[0];
                CFG_GROUP_COUNT:  group_count_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input decode: effective group and range check
    assign in_index = s_tdata[GROUP_W-1:0];
    always_comb begin
        if (group_count_reg == '0) begin
            in_group = '0;
            in_ok    = 1'b1;
        end else begin
            in_group = in_index;
            in_ok    = ({1'b0, in_index} < group_count_reg) && (32'(in_index) < NUM_GROUPS);
        end
    end

    gwsm_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (advance),
        .rd_group (in_group),
        .rd_entry (rd_entry),
        .wr       (st_wr)
    );

    // Stage 1 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (advance) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_action_reg <= s_tuser;
            p1_group_reg  <= in_group;
            p1_ok_reg     <= in_ok;
            p1_value_reg  <= s_tdata[37:6];
            p1_vmiss_reg  <= s_tdata[38];
            p1_weight_reg <= s_tdata[70:39];
            p1_wmiss_reg  <= s_tdata[71];
        end
    end

    // Stage 1: product term and entry forwarding
    assign p1_prod = p1_value_reg * p1_weight_reg;
    always_comb begin
        if (use_weights_reg) begin
            p1_term = p1_prod;
        end else begin
            p1_term = {{(ACC_W-VALUE_W-FRAC_W){p1_value_reg[VALUE_W-1]}},
                       p1_value_reg, {FRAC_W{1'b0}}};
        end
        p1_miss = p1_vmiss_reg || (use_weights_reg && p1_wmiss_reg);
    end

    always_comb begin
        if (p2_valid_reg && p2_ok_reg && p2_group_reg == p1_group_reg) begin
            p1_entry = p2_entry_next;
        end else if (wb_en_reg && wb_group_reg == p1_group_reg) begin
            p1_entry = wb_entry_reg;
        end else begin
            p1_entry = rd_entry;
        end
    end

    // Stage 2 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            wb_en_reg    <= 1'b0;
        end else if (advance) begin
            p2_valid_reg <= p1_valid_reg;
            wb_en_reg    <= st_wr.en;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p2_action_reg <= p1_action_reg;
            p2_group_reg  <= p1_group_reg;
            p2_ok_reg     <= p1_ok_reg;
            p2_miss_reg   <= p1_miss;
            p2_term_reg   <= p1_term;
            p2_entry_reg  <= p1_entry;
            wb_group_reg  <= st_wr.group;
            wb_entry_reg  <= st_wr.entry;
        end
    end

    // Stage 2: group update and read result
    always_comb begin
        p2_entry_next = p2_entry_reg;
        res_sum       = '0;
        res_miss      = 1'b1;
        rd_miss       = p2_entry_reg.poisoned || (skip_missing_reg && !p2_entry_reg.seen);
        if (p2_action_reg == ACT_READ) begin
            if (p2_ok_reg) begin
                res_sum       = rd_miss ? '0 : p2_entry_reg.acc;
                res_miss      = rd_miss;
                p2_entry_next = '0;
            end
        end else if (p2_miss_reg) begin
            if (!skip_missing_reg) begin
                p2_entry_next.poisoned = 1'b1;
            end
        end else if (!p2_entry_reg.poisoned) begin
            p2_entry_next.acc  = sat_add(p2_entry_reg.acc, p2_term_reg);
            p2_entry_next.seen = 1'b1;
        end
    end

    assign st_wr.en    = advance && p2_valid_reg && p2_ok_reg;
    assign st_wr.group = p2_group_reg;
    assign st_wr.entry = p2_entry_next;

    // Output register
    assign m_data_next = {1'b0, p2_group_reg, res_miss, res_sum};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= p2_valid_reg && (p2_action_reg == ACT_READ);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== design/gwsm_store.sv =====
// Per-group state store: one entry memory with registered read, plus per-entry valid flags.
// Depends on gwsm_pkg (entry_t, store_wr_t).
`timescale 1ns / 1ps

module gwsm_store
    import gwsm_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_en,
    input  logic [GROUP_W-1:0] rd_group,
    output entry_t             rd_entry,
    input  store_wr_t          wr
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOTS = 1 << AW;

    entry_t             mem [SLOTS];
    logic [SLOTS-1:0]   valid_reg;
    entry_t             rd_data_reg;
    logic               rd_hit_reg;

    // Entry memory, no reset; unwritten entries are masked by the valid flags
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.group[AW-1:0]] <= wr.entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_group[AW-1:0]];
        end
    end

    // Valid flags: cleared at reset, set on first write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.group[AW-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= valid_reg[rd_group[AW-1:0]];
            end
        end
    end

    // A never-written entry reads as zero state
    assign rd_entry = rd_hit_reg ? rd_data_reg : '0;

endmodule

// ===== design/gwsm_checker.sv =====
// Port-level checks for grouped_weighted_sum_with_missing, attached by bind.
// Sees only the top level's ports; no package dependency.
`timescale 1ns / 1ps

module gwsm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // A held result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result is presented right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Input side stalls only while a result waits on the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output state");

    // A missing result carries a zero sum
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[64] |-> m_tdata[63:0] == 64'd0)
        else $error("missing result with nonzero sum");

endmodule

bind grouped_weighted_sum_with_missing gwsm_checker u_gwsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for grouped_weighted_sum_with_missing: directed and random streams.
// Depends on gwsm_pkg (widths, action codes, register indexes) and the block's top level.
`timescale 1ns / 1ps

module tb_top;
    import gwsm_pkg::*;

    localparam int GROUPS       = 64;
    localparam int DRAIN_CYCLES = 8;      // pipeline is 3 deep; margin on top
    localparam int END_WAIT_MAX = 20000;
    localparam int SETTING_ITEMS = 85;
    localparam longint TIMEOUT_NS = 64'd4_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [VALUE_W-1:0] Q16_MAX = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] Q16_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] Q16_ONE = 32'h0001_0000;
    localparam logic [VALUE_W-1:0] Q16_NEG_HALF = 32'hffff_8000;

    typedef struct {
        logic               action;
        logic [GROUP_W-1:0] group;
        logic [VALUE_W-1:0] value;
        logic               vmiss;
        logic [VALUE_W-1:0] weight;
        logic               wmiss;
    } sample_t;

    typedef struct {
        logic [ACC_W-1:0]   sum;
        logic               missing;
        logic [GROUP_W-1:0] group;
    } group_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata: group_index, sample_value, sample_missing, sample_weight, weight_missing
    logic [S_TDATA_W-1:0]  s_tdata;
    // s_tuser: action
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata: group_sum, sum_is_missing, read_group, zero pad
    logic [M_TDATA_W-1:0]  m_tdata;

    // Predicted block state
    logic [ACC_W-1:0]     acc_model [GROUPS];
    bit                   seen_model [GROUPS];
    bit                   poisoned_model [GROUPS];
    bit                   skip_model;
    bit                   weights_model;
    logic [GCOUNT_W-1:0]  gcount_model;

    group_result_t expected_sums [$];
    int            fail_count;
    int            sent_items;
    int            send_idle_pct;
    int            recv_idle_pct;

    grouped_weighted_sum_with_missing #(
        .NUM_GROUPS(GROUPS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Signed 64-bit add, clamped on overflow
    function automatic logic [ACC_W-1:0] clamp_add(input logic [ACC_W-1:0] a,
                                                   input logic [ACC_W-1:0] b);
        logic [ACC_W:0] wide;
        wide = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (wide[ACC_W] != wide[ACC_W-1]) begin
            return wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return wide[ACC_W-1:0];
    endfunction

    function automatic int eff_groups();
        return (gcount_model > GROUPS) ? GROUPS : int'(gcount_model);
    endfunction

    // Apply one accepted item to the predicted state; queue the read result
    function automatic void predict_group_update(input sample_t s);
        int            eff;
        int            g;
        bit            in_range;
        bit            miss;
        longint        val64;
        longint        wt64;
        longint        term;
        group_result_t r;
        eff = eff_groups();
        if (eff == 0) begin
            g = 0;
            in_range = 1'b1;
        end else begin
            g = int'(s.group);
            in_range = (g < eff);
        end
        if (s.action == ACT_READ) begin
            r.group = g[GROUP_W-1:0];
            if (!in_range) begin
                r.sum = '0;
                r.missing = 1'b1;
            end else begin
                miss = poisoned_model[g] || (skip_model && !seen_model[g]);
                r.sum = miss ? '0 : acc_model[g];
                r.missing = miss;
                acc_model[g] = '0;
                seen_model[g] = 1'b0;
                poisoned_model[g] = 1'b0;
            end
            expected_sums.push_back(r);
            return;
        end
        if (!in_range) return;
        miss = s.vmiss || (weights_model && s.wmiss);
        if (miss) begin
            if (!skip_model) begin
                poisoned_model[g] = 1'b1;
            end
            return;
        end
        if (poisoned_model[g]) return;
        val64 = longint'($signed(s.value));
        wt64  = longint'($signed(s.weight));
        term  = weights_model ? val64 * wt64 : val64 <<< FRAC_W;
        acc_model[g] = clamp_add(acc_model[g], term);
        seen_model[g] = 1'b1;
    endfunction

    function automatic sample_t make_sample(input logic action, input int group,
                                            input logic [VALUE_W-1:0] value,
                                            input logic vmiss,
                                            input logic [VALUE_W-1:0] weight,
                                            input logic wmiss);
        sample_t s;
        s.action = action;
        s.group  = group[GROUP_W-1:0];
        s.value  = value;
        s.vmiss  = vmiss;
        s.weight = weight;
        s.wmiss  = wmiss;
        return s;
    endfunction

    // Random Q16.16 with extra weight on the extremes
    function automatic logic [VALUE_W-1:0] rand_q16();
        case ($urandom_range(9))
            0: return Q16_MAX;
            1: return Q16_MIN;
            2: return '0;
            3, 4: return $urandom_range(32'h0002_0000) - Q16_ONE;
            default: return $urandom;
        endcase
    endfunction

    // One transfer on the input stream, with optional leading idle cycles
    task automatic send_item(input sample_t s);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= s.action;
        s_tdata  <= {s.wmiss, s.weight, s.vmiss, s.value, s.group};
        do @(posedge aclk); while (!s_tready);
        predict_group_update(s);
        sent_items++;
    endtask

    // Stop sending and let every expected result and in-flight accumulate drain
    task automatic wait_idle();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_sums.size() != 0 && waited < END_WAIT_MAX) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One register transfer; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SKIP_MISSING: skip_model = data[0];
            CFG_USE_WEIGHTS:  weights_model = data[0];
            CFG_GROUP_COUNT:  gcount_model = data[GCOUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input bit skip, input bit weights,
                             input logic [GCOUNT_W-1:0] gcount, input bit poke_unused);
        wait_idle();
        if (poke_unused) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(CFG_SKIP_MISSING, {{(CFG_DATA_W-1){1'b0}}, skip});
        write_reg(CFG_USE_WEIGHTS, {{(CFG_DATA_W-1){1'b0}}, weights});
        write_reg(CFG_GROUP_COUNT, gcount);
        cfg_valid <= 1'b0;
    endtask

    // Reset configuration: one ungrouped total, skip-missing, unweighted
    task automatic test_reset_defaults();
        send_item(make_sample(ACT_READ, 5, '0, 1'b0, '0, 1'b0));
        send_item(make_sample(ACT_ACCUM, 9, Q16_MAX, 1'b0, Q16_MIN, 1'b1));
        send_item(make_sample(ACT_ACCUM, 63, Q16_ONE, 1'b1, '0, 1'b0));
        send_item(make_sample(ACT_ACCUM, 0, Q16_MIN, 1'b0, Q16_MAX, 1'b0));
        send_item(make_sample(ACT_READ, 42, '0, 1'b0, '0, 1'b0));
    endtask

    // Poisoning, clearing on read, and mode change with flags kept
    task automatic test_poisoning();
        configure(1'b0, 1'b0, 7'd4, 1'b0);
        send_item(make_sample(ACT_READ, 2, '0, 1'b0, '0, 1'b0));
        send_item(make_sample(ACT_ACCUM, 1, Q16_ONE, 1'b0, '0, 1'b0));
        send_item(make_sample(ACT_ACCUM, 1, Q16_ONE, 1'b1, '0, 1'b0));
        send_item(make_sample(ACT_ACCUM, 1, Q16_NEG_HALF, 1'b0, '0, 1'b0));
        send_item(make_sample(ACT_READ, 1, '0, 1'b0, '0, 1'b0));
        send_item(make_sample(ACT_READ, 1, '0, 1'b0, '0, 1'b0));
        send_item(make_sample(ACT_ACCUM, 3, Q16_ONE, 1'b1, '0, 1'b0));
        configure(1'b1, 1'b0, 7'd4, 1'b1);
        send_item(make_sample(ACT_READ, 3, '0, 1'b0, '0, 1'b0));
        send_item(make_sample(ACT_READ, 0, '0, 1'b0, '0, 1'b0));
    endtask

    // Weighted products at the extremes, saturating both ways
    task automatic test_weighted_saturation();
        configure(1'b1, 1'b1, 7'd64, 1'b0);
        send_item(make_sample(ACT_ACCUM, 63, Q16_MAX, 1'b0, Q16_MAX, 1'b0));
        send_item(make_sample(ACT_ACCUM, 63, Q16_MAX, 1'b0, Q16_MAX, 1'b0));
        send_item(make_sample(ACT_ACCUM, 63, Q16_MIN, 1'b0, Q16_MAX, 1'b1));
        send_item(make_sample(ACT_READ, 63, '0, 1'b0, '0, 1'b0));
        repeat (3) send_item(make_sample(ACT_ACCUM, 0, Q16_MIN, 1'b0, Q16_MAX, 1'b0));
        send_item(make_sample(ACT_ACCUM, 0, Q16_MIN, 1'b0, Q16_MIN, 1'b0));
        send_item(make_sample(ACT_READ, 0, '0, 1'b0, '0, 1'b0));
    endtask

    // Out-of-range indexes, clamped group count, weight flag ignored when unweighted
    task automatic test_group_range();
        configure(1'b0, 1'b1, 7'd5, 1'b0);
        send_item(make_sample(ACT_ACCUM, 5, Q16_ONE, 1'b0, Q16_ONE, 1'b0));
        send_item(make_sample(ACT_READ, 5, '0, 1'b0, '0, 1'b0));
        send_item(make_sample(ACT_READ, 63, '0, 1'b0, '0, 1'b0));
        configure(1'b0, 1'b0, 7'd127, 1'b0);
        send_item(make_sample(ACT_READ, 63, '0, 1'b0, '0, 1'b0));
        send_item(make_sample(ACT_ACCUM, 40, Q16_ONE, 1'b0, '0, 1'b1));
        send_item(make_sample(ACT_READ, 40, '0, 1'b0, '0, 1'b0));
    endtask

    // Mostly accumulate runs closed by a read of the same group, plus loose noise
    task automatic test_random_stream();
        logic [GCOUNT_W-1:0] counts [9] = '{7'd0, 7'd64, 7'd127, 7'd1, 7'd37,
                                             7'd64, 7'd0, 7'd12, 7'd63};
        int start;
        int g;
        int eff;
        int runs;
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 18 : (p == 1) ? 45 : 0;
            recv_idle_pct = (p == 0) ? 45 : (p == 1) ? 18 : 0;
            for (int k = 0; k < 3; k++) begin
                int sidx;
                sidx = p * 3 + k;
                configure(sidx[0], sidx[1], counts[sidx], sidx == 4);
                start = sent_items;
                while (sent_items - start < SETTING_ITEMS) begin
                    eff = eff_groups();
                    if ($urandom_range(99) < 75) begin
                        g = (eff == 0) ? $urandom_range(GROUPS - 1) : $urandom_range(eff - 1);
                        runs = $urandom_range(1, 6);
                        repeat (runs) begin
                            send_item(make_sample(ACT_ACCUM, g, rand_q16(),
                                                  $urandom_range(19) == 0, rand_q16(),
                                                  $urandom_range(19) == 0));
                        end
                        send_item(make_sample(ACT_READ, g, $urandom, 1'($urandom_range(1)),
                                              $urandom, 1'($urandom_range(1))));
                    end else begin
                        send_item(make_sample(1'($urandom_range(1)),
                                              $urandom_range(GROUPS - 1),
                                              rand_q16(), 1'($urandom_range(1)), rand_q16(),
                                              1'($urandom_range(1))));
                    end
                end
            end
        end
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        group_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_sums.size() == 0) begin
                $error("unexpected result: m_tdata %h", m_tdata);
                fail_count++;
            end else begin
                exp_r = expected_sums.pop_front();
                if (m_tdata[63:0] !== exp_r.sum) begin
                    $error("group_sum mismatch: expected %h, got %h", exp_r.sum, m_tdata[63:0]);
                    fail_count++;
                end
                if (m_tdata[64] !== exp_r.missing) begin
                    $error("sum_is_missing mismatch: expected %b, got %b",
                           exp_r.missing, m_tdata[64]);
                    fail_count++;
                end
                if (m_tdata[70:65] !== exp_r.group) begin
                    $error("read_group mismatch: expected %0d, got %0d",
                           exp_r.group, m_tdata[70:65]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_ACCUM;
        m_tready  = 1'b0;
        fail_count = 0;
        sent_items = 0;
        send_idle_pct = 18;
        recv_idle_pct = 45;
        skip_model = 1'b1;
        weights_model = 1'b0;
        gcount_model = '0;
        for (int i = 0; i < GROUPS; i++) begin
            acc_model[i] = '0;
            seen_model[i] = 1'b0;
            poisoned_model[i] = 1'b0;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_poisoning();
        test_weighted_saturation();
        test_group_range();
        test_random_stream();

        wait_idle();
        if (expected_sums.size() != 0) begin
            $error("%0d expected results never arrived", expected_sums.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== grouped_weighted_sum_with_missing.f =====
design/gwsm_pkg.sv
design/gwsm_store.sv
design/grouped_weighted_sum_with_missing.sv
design/gwsm_checker.sv
sim/tb_top.sv
